### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files of the radial beam quad generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property holds in the same cycle as its condition.
`define RBRQ_ASSERT_SAME(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The property holds in the cycle after its condition.
`define RBRQ_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### hw/rtl/rbrq_pkg.sv
// Package with types, constants and tables of the radial beam quad generator.
package rbrq_pkg;

  localparam int COLOR_COUNT = 16;
  localparam int MAX_GATES = 1024;
  localparam int GATE_W = $clog2(MAX_GATES);
  localparam int STEP_W = $clog2(COLOR_COUNT + 1);
  localparam int VALUE_W = 8;
  localparam int AZ_W = 12;
  localparam int BW_W = 7;
  localparam int COLOR_W = 5;
  localparam int COORD_W = 16;
  localparam int IDX_W = 10;
  localparam int TRIG_IDX_W = IDX_W + 1;
  localparam int QUARTER_TURN = 180;
  localparam int HALF_CIRCLE = 360;
  localparam int THREE_QUARTER = 540;
  localparam int HALF_TURN = 720;
  localparam int WRAP_TENTHS = 7200;
  localparam int DIV10_MUL = 6554;
  localparam int DIV10_SHIFT = 16;
  localparam int FRAC_SHIFT = 22;
  localparam int OFFSET_SHIFT = 8;
  localparam int COORD_MAX = 32767;
  localparam int COORD_MIN = -32768;
  localparam int A_W = ((GATE_W + 17 > 24) ? GATE_W + 17 : 24) + 1;
  localparam int P_W = A_W + 18;
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    REG_OFFSET_EAST,
    REG_OFFSET_NORTH,
    REG_SCALE_HORIZONTAL,
    REG_SCALE_VERTICAL,
    REG_CENTER_COLUMN,
    REG_CENTER_ROW,
    REG_DATA_LEVELS,
    REG_UNIT_STEP_MODE
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TRIG,
    BK_CALC,
    BK_EMIT_A,
    BK_EMIT_B
  } bk_state_t;

  typedef logic [QUARTER_TURN:0][14:0] qsin_tab_t;
  typedef logic [255:0][STEP_W-1:0] step_tab_t;

  typedef struct packed {
    logic [GATE_W-1:0]  gate;
    logic               first;
    logic [IDX_W-1:0]   left_idx;
    logic [IDX_W-1:0]   right_idx;
    logic               restart;
    logic               emit_a;
    logic               emit_b;
    logic [COLOR_W-1:0] color_a;
    logic [COLOR_W-1:0] color_b;
  } rbrq_cmd_t;

  typedef struct packed {
    logic signed [15:0] offset_east;
    logic signed [15:0] offset_north;
    logic [15:0]        scale_horizontal;
    logic [15:0]        scale_vertical;
    logic [11:0]        center_column;
    logic [11:0]        center_row;
  } rbrq_geom_t;

  typedef struct packed {
    logic               last;
    logic [COLOR_W-1:0] color;
    logic [3:0][COORD_W-1:0] stop;
    logic [3:0][COORD_W-1:0] start;
  } rbrq_quad_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
  } rbrq_qstat_t;

  typedef struct packed {
    logic busy;
  } rbrq_bstat_t;

  // Quarter sine in Q1.14 for half-degree steps, from a Q30 Taylor series.
  function automatic qsin_tab_t build_qsin_tab();
    qsin_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    for (int k = 0; k <= QUARTER_TURN; k++) begin
      x = (longint'(k) * PI_Q30 + 64'd180) / 64'd360;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum = sum - term;
      term = ((term * x2) >> 30) / 64'd272;
      sum = sum + term;
      tab[k] = 15'((sum + 64'd32768) >> 16);
    end
    return tab;
  endfunction

  // Color step for each level count: the exact quotient when it divides, else one.
  function automatic step_tab_t build_step_tab();
    step_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = STEP_W'(1);
      for (int j = 1; j <= COLOR_COUNT; j++) begin
        if (i * j == COLOR_COUNT) begin
          tab[i] = STEP_W'(j);
        end
      end
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin_tab();
  localparam step_tab_t STEP_TAB = build_step_tab();

  // Sine of a half-degree index, periodic over a full turn, in Q1.14.
  function automatic logic signed [15:0] trig_value(input logic [TRIG_IDX_W-1:0] m);
    logic [TRIG_IDX_W-1:0] mm;
    logic [7:0] k;
    logic neg;
    logic signed [15:0] mag;
    mm = (m >= TRIG_IDX_W'(HALF_TURN)) ? m - TRIG_IDX_W'(HALF_TURN) : m;
    if (mm <= TRIG_IDX_W'(QUARTER_TURN)) begin
      k = 8'(mm);
      neg = 1'b0;
    end else if (mm <= TRIG_IDX_W'(HALF_CIRCLE)) begin
      k = 8'(TRIG_IDX_W'(HALF_CIRCLE) - mm);
      neg = 1'b0;
    end else if (mm <= TRIG_IDX_W'(THREE_QUARTER)) begin
      k = 8'(mm - TRIG_IDX_W'(HALF_CIRCLE));
      neg = 1'b1;
    end else begin
      k = 8'(TRIG_IDX_W'(HALF_TURN) - mm);
      neg = 1'b1;
    end
    mag = signed'({1'b0, QSIN_TAB[k]});
    return neg ? -mag : mag;
  endfunction

endpackage

### hw/rtl/rbrq_queue.sv
// Short command queue between the classifying front end and the quad back end.
module rbrq_queue
  import rbrq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  rbrq_cmd_t   push_data,
  output logic        pop_valid,
  input  logic        pop_ready,
  output rbrq_cmd_t   pop_data,
  output rbrq_qstat_t stat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  rbrq_cmd_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data = entries[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/rbrq_front.sv
// Front end: takes gates, tracks range and runs, and queues one command per gate.
module rbrq_front
  import rbrq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] gate_value,
  input  logic [AZ_W-1:0]    azimuth,
  input  logic [BW_W-1:0]    beam_width,
  input  logic               last_gate,
  input  logic [7:0]         data_levels,
  input  logic               unit_step_mode,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output rbrq_cmd_t          cmd
);

  localparam int EDGE_W = AZ_W + 2;
  localparam int CPROD_W = VALUE_W + STEP_W;
  localparam int QPROD_W = EDGE_W + 13;

  logic [GATE_W-1:0]  gate_counter;
  logic [VALUE_W-1:0] previous_value;
  logic [COLOR_W-1:0] run_color;
  logic accept;

  logic signed [EDGE_W:0] left_diff;
  logic [EDGE_W-1:0] left20;
  logic [EDGE_W-1:0] right20;
  logic [QPROD_W-1:0] left_prod;
  logic [QPROD_W-1:0] right_prod;
  logic [STEP_W-1:0] step;
  logic [CPROD_W-1:0] color_prod;
  logic [COLOR_W-1:0] color_next;
  logic changed;

  assign accept = in_valid && cmd_ready;
  assign in_ready = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    left_diff = signed'({2'b00, azimuth, 1'b0}) - signed'((EDGE_W + 1)'(beam_width));
    if (left_diff[EDGE_W]) begin
      left20 = EDGE_W'(left_diff + signed'((EDGE_W + 1)'(WRAP_TENTHS)));
    end else begin
      left20 = EDGE_W'(left_diff);
    end
    right20 = EDGE_W'({azimuth, 1'b0}) + EDGE_W'(beam_width);
    left_prod = QPROD_W'(left20) * QPROD_W'(DIV10_MUL);
    right_prod = QPROD_W'(right20) * QPROD_W'(DIV10_MUL);

    step = unit_step_mode ? STEP_W'(1) : STEP_TAB[data_levels];
    color_prod = CPROD_W'(gate_value) * CPROD_W'(step);
    if (color_prod > CPROD_W'(COLOR_COUNT)) begin
      color_next = COLOR_W'(COLOR_COUNT);
    end else begin
      color_next = COLOR_W'(color_prod);
    end

    changed = (gate_value != previous_value);

    cmd.gate = gate_counter;
    cmd.first = (gate_counter == '0);
    cmd.left_idx = left_prod[DIV10_SHIFT +: IDX_W];
    cmd.right_idx = right_prod[DIV10_SHIFT +: IDX_W];
    cmd.restart = changed;
    cmd.emit_a = changed && (previous_value != '0) && (data_levels != '0);
    cmd.emit_b = last_gate && (gate_value != '0) && (data_levels != '0);
    cmd.color_a = run_color;
    cmd.color_b = color_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_counter <= '0;
      previous_value <= '0;
      run_color <= '0;
    end else if (accept) begin
      run_color <= color_next;
      if (last_gate) begin
        gate_counter <= '0;
        previous_value <= '0;
      end else begin
        previous_value <= gate_value;
        if (gate_counter != GATE_W'(MAX_GATES - 1)) begin
          gate_counter <= gate_counter + GATE_W'(1);
        end
      end
    end
  end

endmodule

### hw/rtl/rbrq_back.sv
// Back end: loads edge factors, runs the corner pipeline and presents quads.
module rbrq_back
  import rbrq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rbrq_geom_t  geom,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  rbrq_cmd_t   cmd_in,
  output logic        out_valid,
  input  logic        out_ready,
  output rbrq_quad_t  out_quad,
  output rbrq_bstat_t stat
);

  localparam logic [2:0] CALC_ISSUE_END = 3'd3;
  localparam logic [2:0] CALC_LAST = 3'd6;

  bk_state_t state;
  bk_state_t state_next;
  logic [2:0] cnt;
  logic [2:0] cnt_next;
  rbrq_cmd_t cur;
  logic signed [3:0][15:0] edge_trig;
  logic [3:0][COORD_W-1:0] start_corners;
  logic [3:0][COORD_W-1:0] end_corners;

  logic s1_valid;
  logic [1:0] s1_idx;
  logic signed [A_W-1:0] s1_a;
  logic s2_valid;
  logic [1:0] s2_idx;
  logic signed [P_W-1:0] s2_p;

  logic take_cmd;
  logic load_trig;
  logic issue;
  logic slot_free;
  logic load_a;
  logic load_b;
  logic apply_start;

  logic [1:0] issue_idx;
  logic signed [A_W-1:0] g_ext;
  logic signed [A_W-1:0] t_ext;
  logic signed [A_W-1:0] o_ext;
  logic signed [A_W-1:0] a_next;
  logic signed [P_W-1:0] a_ext;
  logic signed [P_W-1:0] s_ext;
  logic signed [P_W-1:0] c_ext;
  logic signed [P_W-1:0] p_next;
  logic signed [P_W-1:0] p_round;
  logic signed [P_W-1:0] q_full;
  logic [COORD_W-1:0] q_sat;

  assign slot_free = !out_valid || out_ready;
  assign stat.busy = (state != BK_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    take_cmd = 1'b0;
    load_trig = 1'b0;
    issue = 1'b0;
    load_a = 1'b0;
    load_b = 1'b0;
    apply_start = 1'b0;
    cmd_ready = 1'b0;
    case (state)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          take_cmd = 1'b1;
          cnt_next = '0;
          state_next = cmd_in.first ? BK_TRIG : BK_CALC;
        end
      end
      BK_TRIG: begin
        load_trig = 1'b1;
        state_next = BK_CALC;
      end
      BK_CALC: begin
        issue = (cnt <= CALC_ISSUE_END);
        cnt_next = cnt + 3'd1;
        if (cnt == CALC_LAST) begin
          if (cur.emit_a) begin
            state_next = BK_EMIT_A;
          end else begin
            apply_start = cur.restart;
            state_next = cur.emit_b ? BK_EMIT_B : BK_IDLE;
          end
        end
      end
      BK_EMIT_A: begin
        if (slot_free) begin
          load_a = 1'b1;
          apply_start = cur.restart;
          state_next = cur.emit_b ? BK_EMIT_B : BK_IDLE;
        end
      end
      BK_EMIT_B: begin
        if (slot_free) begin
          load_b = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      s1_valid <= issue;
      s2_valid <= s1_valid;
      if (load_a || load_b) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Corner k of the end set uses the factor of the opposite edge slot; odd k is a scanline.
  always_comb begin
    issue_idx = cnt[1:0];
    g_ext = A_W'(signed'({1'b0, cur.gate}));
    t_ext = A_W'(signed'(edge_trig[issue_idx ^ 2'd2]));
    o_ext = issue_idx[0] ? A_W'(signed'(geom.offset_north))
                         : A_W'(signed'(geom.offset_east));
    a_next = g_ext * t_ext + (o_ext <<< OFFSET_SHIFT);

    a_ext = P_W'(s1_a);
    s_ext = s1_idx[0] ? P_W'(signed'({1'b0, geom.scale_vertical}))
                      : P_W'(signed'({1'b0, geom.scale_horizontal}));
    c_ext = s1_idx[0] ? P_W'(signed'({1'b0, geom.center_row}))
                      : P_W'(signed'({1'b0, geom.center_column}));
    p_next = a_ext * s_ext + (c_ext <<< FRAC_SHIFT);

    if (s2_p[P_W-1]) begin
      p_round = s2_p + ((P_W'(1) <<< FRAC_SHIFT) - P_W'(1));
    end else begin
      p_round = s2_p;
    end
    q_full = p_round >>> FRAC_SHIFT;
    if (q_full > P_W'(COORD_MAX)) begin
      q_sat = COORD_W'(COORD_MAX);
    end else if (q_full < P_W'(COORD_MIN)) begin
      q_sat = COORD_W'(COORD_MIN);
    end else begin
      q_sat = COORD_W'(q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd) begin
      cur <= cmd_in;
    end
    if (issue) begin
      s1_idx <= issue_idx;
      s1_a <= a_next;
    end
    if (s1_valid) begin
      s2_idx <= s1_idx;
      s2_p <= p_next;
    end
    if (s2_valid) begin
      end_corners[s2_idx] <= q_sat;
    end
    if (load_a) begin
      out_quad.start <= start_corners;
      out_quad.stop <= end_corners;
      out_quad.color <= cur.color_a;
      out_quad.last <= !cur.emit_b;
    end else if (load_b) begin
      out_quad.start <= start_corners;
      out_quad.stop <= end_corners;
      out_quad.color <= cur.color_b;
      out_quad.last <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_trig <= '0;
      start_corners <= '0;
    end else begin
      if (load_trig) begin
        edge_trig[0] <= trig_value(TRIG_IDX_W'(cur.left_idx));
        edge_trig[1] <= trig_value(TRIG_IDX_W'(cur.left_idx) + TRIG_IDX_W'(QUARTER_TURN));
        edge_trig[2] <= trig_value(TRIG_IDX_W'(cur.right_idx));
        edge_trig[3] <= trig_value(TRIG_IDX_W'(cur.right_idx) + TRIG_IDX_W'(QUARTER_TURN));
      end
      if (apply_start) begin
        start_corners[0] <= end_corners[2];
        start_corners[1] <= end_corners[3];
        start_corners[2] <= end_corners[0];
        start_corners[3] <= end_corners[1];
      end
    end
  end

endmodule

### hw/rtl/radial_beam_run_quad_generator.sv
// Top level of the radial beam quad generator: ports, registers and the three parts.
//
// Each transfer on the input carries one radar gate of a beam; gates are counted
// along the beam, the first gate latches the beam-edge azimuths, and each nonzero
// run that ends (value change, drop to zero, or the marked last gate) yields one
// screen quad on the output with its four corners and a capped color index. The
// front end accepts a gate per cycle into a two-entry command queue while the
// queue has room; the back end takes one queued command at a time, loads the
// edge sine and cosine factors on the first gate of a beam, and runs each gate
// through its shared three-stage corner pipeline that computes the four run-end
// corners in turn. With data_levels at zero no quad is produced. Registers are
// to be written only while no gate is in flight; the block itself does not
// enforce this.
module radial_beam_run_quad_generator
  import rbrq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // gate_value [7:0], azimuth [19:8], beam_width [26:20], zero [31:27]
  input  logic [31:0]  s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y (16 bits each from bit 0), color_index [132:128], zero [135:133]
  output logic [135:0] m_tdata,
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

`include "assert_macros.svh"

  rbrq_geom_t geom;
  logic [7:0] data_levels;
  logic unit_step_mode;
  reg_idx_t reg_idx;
  logic cfg_write;

  logic front_valid;
  logic front_ready;
  rbrq_cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  rbrq_cmd_t back_cmd;
  rbrq_qstat_t q_stat;
  rbrq_bstat_t b_stat;
  rbrq_quad_t quad;

  assign pready = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.offset_east <= '0;
      geom.offset_north <= '0;
      geom.scale_horizontal <= 16'd256;
      geom.scale_vertical <= 16'd256;
      geom.center_column <= '0;
      geom.center_row <= '0;
      data_levels <= 8'd16;
      unit_step_mode <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_OFFSET_EAST: geom.offset_east <= pwdata[15:0];
        REG_OFFSET_NORTH: geom.offset_north <= pwdata[15:0];
        REG_SCALE_HORIZONTAL: geom.scale_horizontal <= pwdata[15:0];
        REG_SCALE_VERTICAL: geom.scale_vertical <= pwdata[15:0];
        REG_CENTER_COLUMN: geom.center_column <= pwdata[11:0];
        REG_CENTER_ROW: geom.center_row <= pwdata[11:0];
        REG_DATA_LEVELS: data_levels <= pwdata[7:0];
        REG_UNIT_STEP_MODE: unit_step_mode <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSET_EAST: prdata = {16'd0, geom.offset_east};
      REG_OFFSET_NORTH: prdata = {16'd0, geom.offset_north};
      REG_SCALE_HORIZONTAL: prdata = {16'd0, geom.scale_horizontal};
      REG_SCALE_VERTICAL: prdata = {16'd0, geom.scale_vertical};
      REG_CENTER_COLUMN: prdata = {20'd0, geom.center_column};
      REG_CENTER_ROW: prdata = {20'd0, geom.center_row};
      REG_DATA_LEVELS: prdata = {24'd0, data_levels};
      REG_UNIT_STEP_MODE: prdata = {31'd0, unit_step_mode};
      default: prdata = '0;
    endcase
  end

  rbrq_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .gate_value     (s_tdata[7:0]),
    .azimuth        (s_tdata[19:8]),
    .beam_width     (s_tdata[26:20]),
    .last_gate      (s_tlast),
    .data_levels    (data_levels),
    .unit_step_mode (unit_step_mode),
    .cmd_valid      (front_valid),
    .cmd_ready      (front_ready),
    .cmd            (front_cmd)
  );

  rbrq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd),
    .stat       (q_stat)
  );

  rbrq_back u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd_in    (back_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_quad  (quad),
    .stat      (b_stat)
  );

  assign m_tdata = {3'd0, quad.color, quad.stop, quad.start};
  assign m_tlast = quad.last;

  `RBRQ_ASSERT_NEXT(a_accept_queued, s_tvalid && s_tready, q_stat.count != '0, "accepted gate did not reach the queue")
  `RBRQ_ASSERT_NEXT(a_back_picks_up, back_valid && !b_stat.busy, b_stat.busy, "back end ignored a waiting command")
  `RBRQ_ASSERT_NEXT(a_pair_follows, m_tvalid && m_tready && !m_tlast, m_tvalid, "second quad of a gate did not follow the first")

endmodule
